@@ hw/rtl/assert_macros.svh @@
// Shared assertion macros; clock and reset names follow the house style.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GPF_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GPF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/gpf_pkg.sv @@
`timescale 1ns / 1ps
package gpf_pkg;

   localparam int ADC_W      = 12;
   localparam int PPM_W      = 20;
   localparam int R0_W       = 24;
   localparam int RL_W       = 16;
   localparam int WGT_W      = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int                FULL_W         = 16;
   localparam logic [FULL_W-1:0] ADC_FULL_SCALE = 16'd4095;

   // dividend RL*(FULL-a) and every log2 operand fit this width
   localparam int NUM_W  = RL_W + FULL_W;
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;
   // step counter covers one quotient bit per dividend bit
   localparam int CNT_W  = $clog2(NUM_W);

   localparam logic [PPM_W-1:0] PPM_MAX    = '1;
   localparam logic [13:0]      CURVE_A_Q4 = 14'd16000;
   // floor(2^32 / 5), quotient off by at most one low
   localparam logic [29:0]      RECIP_5    = 30'd858993459;

   localparam logic              RST_CALIBRATED = 1'b0;
   localparam logic [R0_W-1:0]   RST_R0         = 24'd2560;
   localparam logic [RL_W-1:0]   RST_RL         = 16'd2560;
   localparam logic [PPM_W-1:0]  RST_LIMIT      = 20'd16000;
   localparam logic [WGT_W-1:0]  RST_WEIGHT     = 9'd26;
   localparam logic [PPM_W-1:0]  RST_ALERT      = 20'd16000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CALIBRATED = 3'd0,
      CSR_R0         = 3'd1,
      CSR_RL         = 3'd2,
      CSR_LIMIT      = 3'd3,
      CSR_WEIGHT     = 3'd4,
      CSR_ALERT      = 3'd5
   } csr_index_type;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_CLEAR  = 1'b1
   } kind_type;

endpackage

@@ hw/rtl/gpf_req_if.sv @@
`timescale 1ns / 1ps
interface gpf_req_if;
   import gpf_pkg::*;
   logic             valid;
   logic             ready;
   logic             kind;
   logic [ADC_W-1:0] adc_code;

   modport source (output valid, kind, adc_code, input ready);
   modport sink   (input valid, kind, adc_code, output ready);
endinterface

@@ hw/rtl/gpf_rsp_if.sv @@
`timescale 1ns / 1ps
interface gpf_rsp_if;
   import gpf_pkg::*;
   logic             valid;
   logic             ready;
   logic             valid_res;
   logic [PPM_W-1:0] ppm_value;
   logic             rejected;
   logic             alert;

   modport source (output valid, valid_res, ppm_value, rejected, alert, input ready);
   modport sink   (input valid, valid_res, ppm_value, rejected, alert, output ready);
endinterface

@@ hw/rtl/gpf_csr_if.sv @@
`timescale 1ns / 1ps
interface gpf_csr_if;
   import gpf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/gas_ppm_ema_outlier_filter.sv @@
`timescale 1ns / 1ps
// Results: a sample runs the whole datapath before its result is staged; a clear
//   or an uncalibrated sample goes straight to the staged result; each then passes the output register.
// Throughput: one item at a time; a sample's time in the datapath is dominated by sixteen exp2
//   square roots at one root bit per cycle.
// Reset: synchronous, active high; loads register defaults, empties the filter.
`include "assert_macros.svh"
module gas_ppm_ema_outlier_filter (
   input logic        clock,
   input logic        reset,
   gpf_req_if.sink    req_bus,
   gpf_rsp_if.source  rsp_bus,
   gpf_csr_if.sink    csr_bus
);
   import gpf_pkg::*;

   // Sequencer, one-hot
   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_DIV      = 12'b000000000010,
      S_LOG_INIT = 12'b000000000100,
      S_LOG_SQ   = 12'b000000001000,
      S_NSCALE   = 12'b000000010000,
      S_EDIV     = 12'b000000100000,
      S_ECORR    = 12'b000001000000,
      S_EXP_LOAD = 12'b000010000000,
      S_EXP_SQRT = 12'b000100000000,
      S_SCALE    = 12'b001000000000,
      S_FILT     = 12'b010000000000,
      S_DONE     = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic             cal_ff, cal_in;
   logic [R0_W-1:0]  r0_ff, r0_in;
   logic [RL_W-1:0]  rl_ff, rl_in;
   logic [PPM_W-1:0] lim_ff, lim_in;
   logic [WGT_W-1:0] wgt_ff, wgt_in;
   logic [PPM_W-1:0] alvl_ff, alvl_in;

   // Filter state
   logic [PPM_W-1:0] sm_ff, sm_in;
   logic             primed_ff, primed_in;

   // Datapath registers
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]       kcnt_ff, kcnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [ADC_W-1:0] rem_ff, rem_in;
   logic [ADC_W-1:0] dvs_ff, dvs_in;
   logic             sel_ff, sel_in;
   logic [31:0]      m_ff, m_in;
   logic [15:0]      frac_ff, frac_in;
   logic [4:0]       lp_ff, lp_in;
   logic [20:0]      lrs_ff, lrs_in;
   logic [27:0]      nx_ff, nx_in;
   logic             neg_ff, neg_in;
   logic [27:0]      q_ff, q_in;
   logic signed [7:0] ip_ff, ip_in;
   logic [15:0]      f_ff, f_in;
   logic [31:0]      y_ff, y_in;
   logic [63:0]      v_ff, v_in;
   logic [63:0]      r_ff, r_in;
   logic [PPM_W-1:0] raw_ff, raw_in;

   // Staged result and output register
   logic             res_vld_ff, res_vld_in;
   logic [PPM_W-1:0] res_ppm_ff, res_ppm_in;
   logic             res_rej_ff, res_rej_in;
   logic             res_alert_ff, res_alert_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_vld_ff, out_vld_in;
   logic [PPM_W-1:0] out_ppm_ff, out_ppm_in;
   logic             out_rej_ff, out_rej_in;
   logic             out_alert_ff, out_alert_in;

   // Shared multiplier
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;

   function automatic logic [4:0] lead_one(input logic [NUM_W-1:0] x);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < NUM_W; i++) begin
         if (x[i]) p = 5'(i);
      end
      return p;
   endfunction

   // Combinational helpers
   logic [ADC_W-1:0] a_code;
   logic [ADC_W:0]   trial;
   logic             ge;
   logic [NUM_W-1:0] log_x;
   logic [4:0]       log_p;
   logic [32:0]      sq_t;
   logic [20:0]      lr0, mag;
   logic [27:0]      mag11;
   logic [27:0]      qc, rem5;
   logic [28:0]      e_val;
   logic [32:0]      ysh;
   logic [63:0]      bb, rb, r_nx;
   logic [6:0]       sh;
   logic [PROD_W-1:0] scaled;
   logic [PPM_W-1:0] spread;
   logic [WGT_W-1:0] w_eff;
   logic [29:0]      base, s_val;
   logic             load_out;

   assign req_bus.ready    = (state_ff == S_IDLE);
   assign csr_bus.ready    = 1'b1;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.valid_res = out_vld_ff;
   assign rsp_bus.ppm_value = out_ppm_ff;
   assign rsp_bus.rejected  = out_rej_ff;
   assign rsp_bus.alert     = out_alert_ff;

   assign prod = mul_a * mul_b;

   // Steer the single multiplier by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_IDLE: begin
            mul_a = MUL_W'(rl_ff);
            mul_b = MUL_W'(ADC_FULL_SCALE - FULL_W'(a_code));
         end
         S_LOG_SQ: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         S_EDIV: begin
            mul_a = MUL_W'(nx_ff);
            mul_b = MUL_W'(RECIP_5);
         end
         S_SCALE: begin
            mul_a = MUL_W'(CURVE_A_Q4);
            mul_b = y_ff;
         end
         S_FILT: begin
            mul_a = MUL_W'(w_eff);
            mul_b = MUL_W'(spread);
         end
         default: ;
      endcase
   end

   always_comb begin
      // a zero code counts as one
      a_code = (req_bus.adc_code == '0) ? ADC_W'(1) : req_bus.adc_code;

      trial = {rem_ff, quo_ff[NUM_W-1]};
      ge    = (trial >= {1'b0, dvs_ff});

      // log2 operand: rs (zero becomes one LSB) or R0 (same rule)
      if (sel_ff) log_x = (r0_ff == '0) ? NUM_W'(1) : NUM_W'(r0_ff);
      else        log_x = (quo_ff == '0) ? NUM_W'(1) : quo_ff;
      log_p = lead_one(log_x);

      sq_t = prod[63:31];

      lr0   = {lp_ff, frac_ff};
      mag   = (lrs_ff > lr0) ? (lrs_ff - lr0) : (lr0 - lrs_ff);
      mag11 = (28'(mag) << 3) + (28'(mag) << 1) + 28'(mag);

      rem5  = nx_ff - ((q_ff << 2) + q_ff);
      qc    = (rem5 >= 28'd5) ? (q_ff + 28'd1) : q_ff;
      e_val = neg_ff ? (29'd0 - 29'(qc)) : 29'(qc);

      ysh  = f_ff[0] ? {y_ff, 1'b0} : {1'b0, y_ff};
      bb   = 64'd1 << {cnt_ff, 1'b0};
      rb   = r_ff + bb;
      r_nx = (v_ff >= rb) ? ((r_ff >> 1) + bb) : (r_ff >> 1);

      sh     = 7'd30 - 7'(ip_ff);
      scaled = prod >> sh[5:0];

      spread = (raw_ff > sm_ff) ? (raw_ff - sm_ff) : (sm_ff - raw_ff);
      if (wgt_ff == '0)                 w_eff = WGT_W'(1);
      else if (wgt_ff > WGT_W'(256))    w_eff = WGT_W'(256);
      else                              w_eff = wgt_ff;
      base  = {2'b00, sm_ff, 8'd0} + 30'd128;
      s_val = (raw_ff > sm_ff) ? (base + 30'(prod)) : (base - 30'(prod));

      load_out = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);
   end

   always_comb begin
      state_in  = state_ff;
      cal_in    = cal_ff;
      r0_in     = r0_ff;
      rl_in     = rl_ff;
      lim_in    = lim_ff;
      wgt_in    = wgt_ff;
      alvl_in   = alvl_ff;
      sm_in     = sm_ff;
      primed_in = primed_ff;
      cnt_in    = cnt_ff;
      kcnt_in   = kcnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      sel_in    = sel_ff;
      m_in      = m_ff;
      frac_in   = frac_ff;
      lp_in     = lp_ff;
      lrs_in    = lrs_ff;
      nx_in     = nx_ff;
      neg_in    = neg_ff;
      q_in      = q_ff;
      ip_in     = ip_ff;
      f_in      = f_ff;
      y_in      = y_ff;
      v_in      = v_ff;
      r_in      = r_ff;
      raw_in    = raw_ff;
      res_vld_in   = res_vld_ff;
      res_ppm_in   = res_ppm_ff;
      res_rej_in   = res_rej_ff;
      res_alert_in = res_alert_ff;
      rsp_valid_in = rsp_valid_ff;
      out_vld_in   = out_vld_ff;
      out_ppm_in   = out_ppm_ff;
      out_rej_in   = out_rej_ff;
      out_alert_in = out_alert_ff;

      // Register writes; unknown indexes drop
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_CALIBRATED: cal_in  = csr_bus.data[0];
            CSR_R0:         r0_in   = csr_bus.data[R0_W-1:0];
            CSR_RL:         rl_in   = csr_bus.data[RL_W-1:0];
            CSR_LIMIT:      lim_in  = csr_bus.data[PPM_W-1:0];
            CSR_WEIGHT:     wgt_in  = csr_bus.data[WGT_W-1:0];
            CSR_ALERT:      alvl_in = csr_bus.data[PPM_W-1:0];
            default: ;
         endcase
      end

      // Output register: drop on transfer, reload from stage
      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         out_vld_in   = res_vld_ff;
         out_ppm_in   = res_ppm_ff;
         out_rej_in   = res_rej_ff;
         out_alert_in = res_alert_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               res_rej_in = 1'b0;
               res_ppm_in = '0;
               if (req_bus.kind == KIND_CLEAR) begin
                  sm_in        = '0;
                  primed_in    = 1'b0;
                  res_vld_in   = 1'b1;
                  res_alert_in = (alvl_ff == '0);
                  state_in     = S_DONE;
               end else if (!cal_ff) begin
                  res_vld_in   = 1'b0;
                  res_alert_in = (sm_ff >= alvl_ff);
                  state_in     = S_DONE;
               end else begin
                  // load dividend RL*(FULL-a); full-scale code gives rs of zero
                  quo_in   = (FULL_W'(a_code) < ADC_FULL_SCALE) ? NUM_W'(prod) : '0;
                  rem_in   = '0;
                  dvs_in   = a_code;
                  cnt_in   = CNT_W'(NUM_W - 1);
                  sel_in   = 1'b0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // one quotient bit per cycle
            rem_in = ge ? ADC_W'(trial - {1'b0, dvs_ff}) : trial[ADC_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = S_LOG_INIT;
         end
         S_LOG_INIT: begin
            // normalize to a Q1.31 mantissa
            lp_in    = log_p;
            m_in     = 32'(log_x << (5'd31 - log_p));
            frac_in  = '0;
            cnt_in   = CNT_W'(15);
            state_in = S_LOG_SQ;
         end
         S_LOG_SQ: begin
            // square the mantissa, one fraction bit per cycle
            m_in    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
            frac_in = frac_ff | (16'(sq_t[32]) << cnt_ff[3:0]);
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (!sel_ff) begin
                  lrs_in   = {lp_ff, frac_in};
                  sel_in   = 1'b1;
                  state_in = S_LOG_INIT;
               end else begin
                  state_in = S_NSCALE;
               end
            end
         end
         S_NSCALE: begin
            // exponent -2.2 * diff: magnitude 11*|diff|, biased for floor when negative
            neg_in   = (lrs_ff > lr0);
            nx_in    = (lrs_ff > lr0) ? (mag11 + 28'd4) : mag11;
            state_in = S_EDIV;
         end
         S_EDIV: begin
            q_in     = 28'(prod >> 32);
            state_in = S_ECORR;
         end
         S_ECORR: begin
            ip_in    = 8'($signed(e_val) >>> 16);
            f_in     = e_val[15:0];
            y_in     = 32'd1 << 30;
            kcnt_in  = '0;
            state_in = S_EXP_LOAD;
         end
         S_EXP_LOAD: begin
            // double on a set fraction bit, then take sqrt(y * 2^30)
            v_in     = 64'(ysh) << 30;
            f_in     = f_ff >> 1;
            r_in     = '0;
            cnt_in   = CNT_W'(31);
            state_in = S_EXP_SQRT;
         end
         S_EXP_SQRT: begin
            if (v_ff >= rb) v_in = v_ff - rb;
            r_in   = r_nx;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               y_in    = r_nx[31:0];
               kcnt_in = kcnt_ff + 1'b1;
               if (kcnt_ff == 4'd15) state_in = S_SCALE;
               else                  state_in = S_EXP_LOAD;
            end
         end
         S_SCALE: begin
            if (ip_ff > 8'sd6)           raw_in = PPM_MAX;
            else if (ip_ff < -8'sd33)    raw_in = '0;
            else if (scaled > PROD_W'(PPM_MAX)) raw_in = PPM_MAX;
            else                         raw_in = scaled[PPM_W-1:0];
            state_in = S_FILT;
         end
         S_FILT: begin
            res_vld_in = 1'b1;
            res_rej_in = 1'b0;
            if (!primed_ff) begin
               // first sample seeds the average
               sm_in        = raw_ff;
               primed_in    = 1'b1;
               res_ppm_in   = raw_ff;
               res_alert_in = (raw_ff >= alvl_ff);
            end else if (spread > lim_ff) begin
               // outlier: hold the old value
               res_rej_in   = 1'b1;
               res_ppm_in   = sm_ff;
               res_alert_in = (sm_ff >= alvl_ff);
            end else begin
               sm_in        = s_val[27:8];
               res_ppm_in   = s_val[27:8];
               res_alert_in = (s_val[27:8] >= alvl_ff);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_out) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cal_ff       <= RST_CALIBRATED;
         r0_ff        <= RST_R0;
         rl_ff        <= RST_RL;
         lim_ff       <= RST_LIMIT;
         wgt_ff       <= RST_WEIGHT;
         alvl_ff      <= RST_ALERT;
         sm_ff        <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cal_ff       <= cal_in;
         r0_ff        <= r0_in;
         rl_ff        <= rl_in;
         lim_ff       <= lim_in;
         wgt_ff       <= wgt_in;
         alvl_ff      <= alvl_in;
         sm_ff        <= sm_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      kcnt_ff      <= kcnt_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      sel_ff       <= sel_in;
      m_ff         <= m_in;
      frac_ff      <= frac_in;
      lp_ff        <= lp_in;
      lrs_ff       <= lrs_in;
      nx_ff        <= nx_in;
      neg_ff       <= neg_in;
      q_ff         <= q_in;
      ip_ff        <= ip_in;
      f_ff         <= f_in;
      y_ff         <= y_in;
      v_ff         <= v_in;
      r_ff         <= r_in;
      raw_ff       <= raw_in;
      res_vld_ff   <= res_vld_in;
      res_ppm_ff   <= res_ppm_in;
      res_rej_ff   <= res_rej_in;
      res_alert_ff <= res_alert_in;
      out_vld_ff   <= out_vld_in;
      out_ppm_ff   <= out_ppm_in;
      out_rej_ff   <= out_rej_in;
      out_alert_ff <= out_alert_in;
   end

   // An accepted item keeps the input closed on the next cycle
   `GPF_ASSERT_NEXT(a_busy_after_accept, req_bus.valid && req_bus.ready, !req_bus.ready, "input open right after a transfer")
   // A waiting result is never overwritten
   `GPF_ASSERT_NEXT(a_hold_done, (state_ff == S_DONE) && rsp_valid_ff && !rsp_bus.ready, (state_ff == S_DONE) && rsp_valid_ff, "stalled result lost")
   // An empty filter holds zero
   `GPF_ASSERT_IMPL(a_empty_zero, !primed_ff, sm_ff == '0, "unprimed filter not zero")

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import gpf_pkg::*;

   logic clock;
   logic reset;

   gpf_req_if req_bus ();
   gpf_rsp_if rsp_bus ();
   gpf_csr_if csr_bus ();

   gas_ppm_ema_outlier_filter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 700;
   localparam int RANDOM_ITEMS   = 680;

   typedef struct packed {
      logic             valid_res;
      logic [PPM_W-1:0] ppm_value;
      logic             rejected;
      logic             alert;
   } reading_type;

   // one row of the directed table; has_exp marks rows with a typed-in result
   typedef struct {
      kind_type         kind;
      logic [ADC_W-1:0] adc;
      bit               has_exp;
      reading_type      exp;
   } stim_row_type;

   // predictor copy of the configuration and filter state
   logic              cal_q;
   logic [R0_W-1:0]   r0_q;
   logic [RL_W-1:0]   rl_q;
   logic [PPM_W-1:0]  limit_q;
   logic [WGT_W-1:0]  weight_q;
   logic [PPM_W-1:0]  alert_q;
   logic [PPM_W-1:0]  ema_q;
   logic              primed_q;

   reading_type pending_readings[$];
   int          fail_count;
   int          idle_cycles;
   int          send_idle_pct;
   int          recv_idle_pct;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // floor integer square root, bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // log2 in Q.16 by leading one plus repeated squaring of a Q1.31 mantissa
   function automatic longint log2_fix(input logic [63:0] x);
      int          p;
      logic [63:0] m;
      longint      frac;
      p = 63;
      frac = 0;
      while (p > 0 && x[p] == 1'b0) p--;
      m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            frac = frac | (longint'(1) << i);
         end
      end
      return longint'(p) * 65536 + frac;
   endfunction

   function automatic logic [PPM_W-1:0] adc_to_ppm(input logic [ADC_W-1:0] adc);
      logic [63:0] a, r0, rs, f, y, v;
      longint      n, e, ip;
      a  = (adc == 0) ? 64'd1 : 64'(adc);
      r0 = (r0_q == 0) ? 64'd1 : 64'(r0_q);
      rs = '0;
      if (a < 64'(ADC_FULL_SCALE)) rs = (64'(rl_q) * (64'(ADC_FULL_SCALE) - a)) / a;
      if (rs == 0) rs = 64'd1;
      n = -11 * (log2_fix(rs) - log2_fix(r0));
      // floor division for both signs
      e = (n >= 0) ? n / 5 : -((-n + 4) / 5);
      ip = (e >= 0) ? e / 65536 : -((-e + 65535) / 65536);
      f = 64'(e - ip * 65536);
      y = 64'd1 << 30;
      for (int k = 0; k < 16; k++) begin
         if (f[k]) y = y << 1;
         y = isqrt64(y << 30);
      end
      if (ip > 6) return PPM_MAX;
      if (30 - ip > 63) return '0;
      v = (64'(CURVE_A_Q4) * y) >> (30 - ip);
      return (v > 64'(PPM_MAX)) ? PPM_MAX : v[PPM_W-1:0];
   endfunction

   // advance filter state for one accepted item and return its reading
   function automatic reading_type filter_step(input kind_type kind,
                                               input logic [ADC_W-1:0] adc);
      reading_type      r;
      logic [PPM_W-1:0] raw, spread;
      logic [63:0]      w, s;
      r = '{valid_res: 1'b1, ppm_value: '0, rejected: 1'b0, alert: 1'b0};
      if (kind == KIND_CLEAR) begin
         ema_q = '0;
         primed_q = 1'b0;
      end else if (!cal_q) begin
         r.valid_res = 1'b0;
      end else begin
         raw = adc_to_ppm(adc);
         if (!primed_q) begin
            ema_q = raw;
            primed_q = 1'b1;
         end else begin
            spread = (raw > ema_q) ? raw - ema_q : ema_q - raw;
            if (spread > limit_q) begin
               r.rejected = 1'b1;
            end else begin
               w = 64'(weight_q);
               if (w == 0) w = 1;
               if (w > 256) w = 256;
               s = (w * raw + (256 - w) * ema_q + 128) >> 8;
               ema_q = s[PPM_W-1:0];
            end
         end
         r.ppm_value = ema_q;
      end
      r.alert = (ema_q >= alert_q);
      return r;
   endfunction

   // let the block drain, then write one register
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      while (pending_readings.size() != 0) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_CALIBRATED: cal_q    = data[0];
         CSR_R0:         r0_q     = data[R0_W-1:0];
         CSR_RL:         rl_q     = data[RL_W-1:0];
         CSR_LIMIT:      limit_q  = data[PPM_W-1:0];
         CSR_WEIGHT:     weight_q = data[WGT_W-1:0];
         CSR_ALERT:      alert_q  = data[PPM_W-1:0];
         default: ;
      endcase
      // hold valid low before the next write
      @(posedge clock);
   endtask

   task automatic send_item(input kind_type kind, input logic [ADC_W-1:0] adc,
                            input bit has_exp, input reading_type exp);
      reading_type pred;
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.kind     <= kind;
      req_bus.adc_code <= adc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pred = filter_step(kind, adc);
      if (has_exp && pred != exp) begin
         $error("directed row disagrees with predictor: %h vs %h", exp, pred);
         fail_count++;
      end
      pending_readings.push_back(has_exp ? exp : pred);
      req_bus.valid <= 1'b0;
      // the block is busy on the cycle after a transfer
      @(posedge clock);
   endtask

   task automatic random_config();
      write_csr(CSR_R0, ($urandom_range(3) == 0) ? CSR_DATA_W'($urandom)
                                                  : CSR_DATA_W'($urandom_range(200, 20000)));
      write_csr(CSR_RL, ($urandom_range(3) == 0) ? CSR_DATA_W'($urandom_range(65535))
                                                  : CSR_DATA_W'($urandom_range(500, 8000)));
      write_csr(CSR_LIMIT, CSR_DATA_W'($urandom_range(3) == 0 ? $urandom_range(1048575)
                                                             : $urandom_range(0, 40000)));
      write_csr(CSR_WEIGHT, CSR_DATA_W'($urandom_range(511)));
      write_csr(CSR_ALERT, CSR_DATA_W'($urandom_range(1048575) >> $urandom_range(8)));
   endtask

   // receiver: random backpressure, compare with the oldest expectation
   always @(posedge clock) begin
      reading_type got, exp;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.valid_res, rsp_bus.ppm_value, rsp_bus.rejected, rsp_bus.alert};
            if (pending_readings.size() == 0) begin
               $error("unexpected result transfer %h", got);
               fail_count++;
            end else begin
               exp = pending_readings.pop_front();
               if (got.valid_res !== exp.valid_res) begin
                  $error("valid_res exp %0d got %0d", exp.valid_res, got.valid_res);
                  fail_count++;
               end
               if (got.ppm_value !== exp.ppm_value) begin
                  $error("ppm_value exp %0d got %0d", exp.ppm_value, got.ppm_value);
                  fail_count++;
               end
               if (got.rejected !== exp.rejected) begin
                  $error("rejected exp %0d got %0d", exp.rejected, got.rejected);
                  fail_count++;
               end
               if (got.alert !== exp.alert) begin
                  $error("alert exp %0d got %0d", exp.alert, got.alert);
                  fail_count++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: count cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type rows[$];
      reading_type  nx;
      int           n;
      nx = '0;
      fail_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_SAMPLE;
      req_bus.adc_code = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_CALIBRATED;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      cal_q = RST_CALIBRATED;
      r0_q = RST_R0;
      rl_q = RST_RL;
      limit_q = RST_LIMIT;
      weight_q = RST_WEIGHT;
      alert_q = RST_ALERT;
      ema_q = '0;
      primed_q = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // uncalibrated after reset: samples read invalid, zero, alert false; a clear reads valid
      send_idle_pct = 25;
      recv_idle_pct = 66;
      rows.push_back('{KIND_SAMPLE, 12'd2048, 1'b1, '{1'b0, 20'd0, 1'b0, 1'b0}});
      rows.push_back('{KIND_SAMPLE, 12'hFFF, 1'b1, '{1'b0, 20'd0, 1'b0, 1'b0}});
      rows.push_back('{KIND_CLEAR, 12'hABC, 1'b1, '{1'b1, 20'd0, 1'b0, 1'b0}});
      foreach (rows[i]) send_item(rows[i].kind, rows[i].adc, rows[i].has_exp, rows[i].exp);
      rows.delete();

      write_csr(CSR_CALIBRATED, 24'd1);
      // extremes of the code: zero, one, full scale and just below, mid codes
      rows.push_back('{KIND_SAMPLE, 12'd0, 1'b0, nx});
      rows.push_back('{KIND_SAMPLE, 12'd1, 1'b0, nx});
      rows.push_back('{KIND_SAMPLE, 12'd4095, 1'b0, nx});
      rows.push_back('{KIND_CLEAR, 12'd0, 1'b1, '{1'b1, 20'd0, 1'b0, 1'b0}});
      rows.push_back('{KIND_SAMPLE, 12'd4095, 1'b1, '{1'b1, PPM_MAX, 1'b0, 1'b1}});
      rows.push_back('{KIND_SAMPLE, 12'd4094, 1'b0, nx});
      rows.push_back('{KIND_SAMPLE, 12'd2048, 1'b0, nx});
      rows.push_back('{KIND_CLEAR, 12'hFFF, 1'b1, '{1'b1, 20'd0, 1'b0, 1'b0}});
      rows.push_back('{KIND_SAMPLE, 12'd2048, 1'b0, nx});
      rows.push_back('{KIND_SAMPLE, 12'd2000, 1'b0, nx});
      rows.push_back('{KIND_SAMPLE, 12'd1365, 1'b0, nx});
      rows.push_back('{KIND_SAMPLE, 12'd2730, 1'b0, nx});
      foreach (rows[i]) send_item(rows[i].kind, rows[i].adc, rows[i].has_exp, rows[i].exp);
      rows.delete();

      // extreme register settings: weight 0/511/256, R0 0/max, RL max/1, limit and alert 0/max
      write_csr(CSR_WEIGHT, 24'd0);
      write_csr(CSR_R0, 24'd0);
      write_csr(CSR_LIMIT, 24'd0);
      write_csr(CSR_ALERT, 24'd0);
      send_item(KIND_SAMPLE, 12'd3000, 1'b0, nx);
      send_item(KIND_SAMPLE, 12'd100, 1'b0, nx);
      write_csr(CSR_WEIGHT, 24'd511);
      write_csr(CSR_R0, 24'hFFFFFF);
      write_csr(CSR_RL, 24'd65535);
      write_csr(CSR_LIMIT, 24'hFFFFF);
      write_csr(CSR_ALERT, 24'hFFFFF);
      send_item(KIND_SAMPLE, 12'd1, 1'b0, nx);
      send_item(KIND_SAMPLE, 12'd4000, 1'b0, nx);
      write_csr(CSR_RL, 24'd1);
      send_item(KIND_SAMPLE, 12'd2, 1'b0, nx);
      write_csr(CSR_WEIGHT, 24'd256);
      send_item(KIND_SAMPLE, 12'd3, 1'b0, nx);

      // random part in three idling phases, settings changed per burst
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 66;
            recv_idle_pct = 25;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n % 40 == 0) begin
            random_config();
            write_csr(CSR_CALIBRATED, CSR_DATA_W'($urandom_range(7) != 0));
            // pause after the new settings before the next item
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         if ($urandom_range(19) == 0) begin
            send_item(KIND_CLEAR, ADC_W'($urandom), 1'b0, nx);
         end else if ($urandom_range(4) == 0) begin
            send_item(KIND_SAMPLE, ADC_W'($urandom), 1'b0, nx);
         end else begin
            // near a running level so the filter updates rather than rejects
            send_item(KIND_SAMPLE, ADC_W'($urandom_range(1500, 2600)), 1'b0, nx);
         end
         n++;
         // hold the sender until the block has answered everything
         if (n % 97 == 0)
            while (pending_readings.size() != 0) @(posedge clock);
      end

      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_readings.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
